FILE: design/pcmr_pkg.sv
// ----------------------------------------------------------------------------
// pcmr_pkg
// shared types and fixed field widths of the polygon coverage rasterizer
// ----------------------------------------------------------------------------
package pcmr_pkg;

  // fixed field widths
  localparam int COORD_W  = 16;
  localparam int INDEX_W  = 3;
  localparam int PIXEL_W  = 8;
  localparam int ALPHA_W  = 8;
  localparam int HITS_W   = 5;
  localparam int VCOUNT_W = 4;

  // vertex count lower limit and reset value
  localparam int VCOUNT_MIN   = 3;
  localparam int VCOUNT_RESET = 3;

  // sub-pixel geometry: one pixel is 16 units, samples sit half a step in
  localparam int PIXEL_SUBUNITS = 16;
  localparam int SAMPLE_HALF    = 8;

  // full-scale alpha
  localparam int FULL_ALPHA = 255;

  typedef enum logic [0:0] {
    CMD_WRITE_VERTEX = 1'b0,
    CMD_EVAL_PIXEL   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

FILE: design/pcmr_if.sv
// ----------------------------------------------------------------------------
// pcmr channel interfaces
// item, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pcmr_item_if;
  logic                                 valid;
  logic                                 ready;
  pcmr_pkg::cmd_t                       command;
  logic        [pcmr_pkg::INDEX_W-1:0]  vertex_index;
  logic signed [pcmr_pkg::COORD_W-1:0]  vertex_x;
  logic signed [pcmr_pkg::COORD_W-1:0]  vertex_y;
  logic        [pcmr_pkg::PIXEL_W-1:0]  pixel_x;
  logic        [pcmr_pkg::PIXEL_W-1:0]  pixel_y;

  modport source (output valid, command, vertex_index, vertex_x, vertex_y, pixel_x, pixel_y,
                  input ready);
  modport sink (input valid, command, vertex_index, vertex_x, vertex_y, pixel_x, pixel_y,
                output ready);
endinterface

interface pcmr_result_if;
  logic                            valid;
  logic                            ready;
  logic [pcmr_pkg::ALPHA_W-1:0]    coverage;
  logic [pcmr_pkg::HITS_W-1:0]     sample_hits;

  modport source (output valid, coverage, sample_hits, input ready);
  modport sink (input valid, coverage, sample_hits, output ready);
endinterface

interface pcmr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pcmr_pkg::VCOUNT_W-1:0]   vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

FILE: design/polygon_coverage_mask_raster.sv
// ----------------------------------------------------------------------------
// polygon_coverage_mask_raster
// 4x4 supersampled even-odd coverage of one mask pixel against a polygon
// ----------------------------------------------------------------------------
// usage
//   cfg carries vertex_count (corners in use, clamped to 3..MAX_VERTICES);
//   write it only while the block is idle. cfg is always ready.
//   item carries either a vertex write (command = write vertex) or a pixel
//   evaluation (command = eval pixel). item.ready is high while no pixel is
//   in flight.
//   a vertex write gives no result; the vertex lands in the corner ram at
//   the accepting edge, so a pixel may follow at once.
//   a pixel transaction gives one result transaction (coverage, sample_hits).
// timing
//   the corner ram has one read port; one edge is read per cycle, n + 1
//   reads for n corners (the last corner first, so every edge finds its
//   previous vertex already in hand). edges then pass a four-stage pipe
//   (deltas, products, constant term, per-sample compares) that flips one
//   parity bit per sample. result valid rises as the block returns to idle,
//   so the next item can be accepted while that result is first offered.
// reset and stalls
//   rst clears the control state and sets vertex_count to 3; corner ram
//   contents stay undefined until written.
//   the result sits in an output register; if the receiver stalls, the
//   block still takes vertex writes and one further pixel, which then waits
//   for the output register to free before its result is loaded.
// ----------------------------------------------------------------------------
module polygon_coverage_mask_raster #(
  parameter int MAX_VERTICES = 8,
  parameter int SUBSAMPLE    = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  pcmr_item_if.sink            item,
  pcmr_result_if.source        result,
  pcmr_cfg_if.sink             cfg
);

  // derived sizes
  localparam int AW     = $clog2(MAX_VERTICES);
  localparam int NW     = $clog2(MAX_VERTICES + 2);
  localparam int SS     = SUBSAMPLE * SUBSAMPLE;
  localparam int LOG_S  = $clog2(SUBSAMPLE);
  localparam int SCW    = pcmr_pkg::COORD_W + LOG_S;      // scaled coordinate
  localparam int DW     = SCW + 1;                         // coordinate difference
  localparam int OFW    = LOG_S + 6;                       // sample offset constant
  localparam int RW     = DW + OFW;                        // offset times delta
  localparam int PW     = 2 * DW;                          // delta product
  localparam int SW     = PW + 2;                          // crossing sum
  localparam int HW     = $clog2(SS + 1);
  localparam int RAM_W  = 2 * pcmr_pkg::COORD_W;
  localparam int K      = 24;
  localparam int MW     = HW + pcmr_pkg::ALPHA_W + K + 2;
  localparam logic [K:0]    RECIP   = (K + 1)'(((64'd1 << K) + 64'(SS) - 64'd1) / 64'(SS));
  localparam logic [MW-1:0] COV_MUL = MW'(64'(pcmr_pkg::FULL_ALPHA) * 64'(RECIP));
  localparam logic signed [DW-1:0] SUB_D = DW'(SUBSAMPLE);

  // control
  pcmr_pkg::state_t state, state_next;
  logic [pcmr_pkg::VCOUNT_W-1:0] vertex_count;
  logic [NW-1:0] n_clamp;
  logic [NW-1:0] n_reg;
  logic [NW-1:0] rd_cnt;
  logic [NW-1:0] done_cnt;
  logic          in_acc;
  logic          pix_acc;
  logic          rd_issue;
  logic          out_free;
  logic          out_load;

  // corner ram
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [RAM_W-1:0] ram_rdata;
  logic             rv;
  logic             rfirst;

  // pixel base in scaled sample units
  logic signed [DW-1:0] bx;
  logic signed [DW-1:0] by;

  // stage 1: deltas
  logic signed [DW-1:0] cur_xs, cur_ys, prev_xs, prev_ys;
  logic                 e1_vld;
  logic signed [DW-1:0] dx1, dy1, ex1, ey1, yi1, yj1;

  // stage 2: products
  logic                 e2_vld;
  logic signed [PW-1:0] m1, m2;
  logic signed [RW-1:0] ra2 [SUBSAMPLE];
  logic signed [RW-1:0] cb2 [SUBSAMPLE];
  logic [SUBSAMPLE-1:0] row2;
  logic                 pos2;
  logic signed [DW-1:0] sy [SUBSAMPLE];

  // stage 3: per-edge constant term
  logic                 e3_vld;
  logic signed [SW-1:0] p3;
  logic signed [RW-1:0] ra3 [SUBSAMPLE];
  logic signed [RW-1:0] cb3 [SUBSAMPLE];
  logic [SUBSAMPLE-1:0] row3;
  logic                 pos3;

  // stage 4: sample compares and parity
  logic signed [SW-1:0] diff [SS];
  logic [SS-1:0]        flip;
  logic [SS-1:0]        parity;

  // result
  logic [HW-1:0] hit_sum;
  logic [HW-1:0] hits;
  logic [MW-1:0] cov_prod;

  // --------------------------------------------------------------------------
  // configuration register and corner count clamp
  // --------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= pcmr_pkg::VCOUNT_W'(pcmr_pkg::VCOUNT_RESET);
    end else if (cfg.valid && cfg.ready) begin
      vertex_count <= cfg.vertex_count;
    end
  end

  always_comb begin
    if (32'(vertex_count) < pcmr_pkg::VCOUNT_MIN) begin
      n_clamp = NW'(pcmr_pkg::VCOUNT_MIN);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_clamp = NW'(MAX_VERTICES);
    end else begin
      n_clamp = NW'(vertex_count);
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_acc   = item.valid && item.ready;
  assign pix_acc  = in_acc && (item.command == pcmr_pkg::CMD_EVAL_PIXEL);
  assign out_free = !result.valid || result.ready;

  always_comb begin
    state_next = state;
    case (state)
      pcmr_pkg::ST_IDLE: begin
        if (pix_acc) begin
          state_next = pcmr_pkg::ST_RUN;
        end
      end
      pcmr_pkg::ST_RUN: begin
        // all edges have left the compare stage
        if (done_cnt == n_reg) begin
          state_next = pcmr_pkg::ST_FIN;
        end
      end
      pcmr_pkg::ST_FIN: begin
        state_next = pcmr_pkg::ST_OUT;
      end
      pcmr_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = pcmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcmr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    rd_issue   = 1'b0;
    out_load   = 1'b0;
    case (state)
      pcmr_pkg::ST_IDLE: begin
        item.ready = 1'b1;
      end
      pcmr_pkg::ST_RUN: begin
        rd_issue = (rd_cnt <= n_reg);
      end
      pcmr_pkg::ST_OUT: begin
        out_load = out_free;
      end
      default: begin
        item.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pcmr_pkg::ST_IDLE;
      rd_cnt   <= '0;
      done_cnt <= '0;
      rv       <= 1'b0;
      rfirst   <= 1'b0;
      e1_vld   <= 1'b0;
      e2_vld   <= 1'b0;
      e3_vld   <= 1'b0;
    end else begin
      state  <= state_next;
      rv     <= rd_issue;
      rfirst <= rd_issue && (rd_cnt == '0);
      e1_vld <= rv && !rfirst;
      e2_vld <= e1_vld;
      e3_vld <= e2_vld;
      if (pix_acc) begin
        rd_cnt   <= '0;
        done_cnt <= '0;
      end else begin
        if (rd_issue) begin
          rd_cnt <= rd_cnt + 1'b1;
        end
        if (e3_vld) begin
          done_cnt <= done_cnt + 1'b1;
        end
      end
    end
  end

  // pixel context, held for the whole evaluation
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      n_reg <= n_clamp;
      bx    <= DW'(item.pixel_x) * DW'(pcmr_pkg::PIXEL_SUBUNITS * SUBSAMPLE);
      by    <= DW'(item.pixel_y) * DW'(pcmr_pkg::PIXEL_SUBUNITS * SUBSAMPLE);
    end
  end

  // --------------------------------------------------------------------------
  // corner ram: x in the upper half, y in the lower half
  // --------------------------------------------------------------------------
  assign ram_we    = in_acc && (item.command == pcmr_pkg::CMD_WRITE_VERTEX)
                     && (32'(item.vertex_index) < MAX_VERTICES);
  assign ram_waddr = AW'(item.vertex_index);
  assign ram_wdata = {item.vertex_x, item.vertex_y};
  // last corner first, then corners 0 .. n-1
  assign ram_raddr = (rd_cnt == '0) ? AW'(n_reg - 1'b1) : AW'(rd_cnt - 1'b1);

  pcmr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_VERTICES)
  ) u_corner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: scale the corner, form edge deltas against the previous corner
  // --------------------------------------------------------------------------
  assign cur_xs = DW'($signed(ram_rdata[RAM_W-1 -: pcmr_pkg::COORD_W])) * SUB_D;
  assign cur_ys = DW'($signed(ram_rdata[pcmr_pkg::COORD_W-1:0])) * SUB_D;

  always_ff @(posedge clk) begin
    if (rv) begin
      prev_xs <= cur_xs;
      prev_ys <= cur_ys;
    end
    // edge from corner i (current) to corner j (previous)
    dx1 <= prev_xs - cur_xs;
    dy1 <= prev_ys - cur_ys;
    ex1 <= bx - cur_xs;
    ey1 <= by - cur_ys;
    yi1 <= cur_ys;
    yj1 <= prev_ys;
  end

  // --------------------------------------------------------------------------
  // stage 2: cross products and per-row / per-column offset terms
  // --------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < SUBSAMPLE; k++) begin
      sy[k] = by + DW'((2 * k + 1) * pcmr_pkg::SAMPLE_HALF);
    end
  end

  always_ff @(posedge clk) begin
    m1   <= ey1 * dx1;
    m2   <= ex1 * dy1;
    pos2 <= !dy1[DW-1] && (dy1 != '0);
    for (int k = 0; k < SUBSAMPLE; k++) begin
      ra2[k]  <= RW'(dx1) * RW'((2 * k + 1) * pcmr_pkg::SAMPLE_HALF);
      cb2[k]  <= RW'(dy1) * RW'((2 * k + 1) * pcmr_pkg::SAMPLE_HALF);
      // sample row lies between the edge's end points (horizontal edges never)
      row2[k] <= (yi1 > sy[k]) != (yj1 > sy[k]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: constant part of rhs - lhs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    p3   <= SW'(m1) - SW'(m2);
    pos3 <= pos2;
    row3 <= row2;
    for (int k = 0; k < SUBSAMPLE; k++) begin
      ra3[k] <= ra2[k];
      cb3[k] <= cb2[k];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: one comparator per sample, toggle parity on a crossing
  // --------------------------------------------------------------------------
  always_comb begin
    for (int a = 0; a < SUBSAMPLE; a++) begin
      for (int b = 0; b < SUBSAMPLE; b++) begin
        diff[a * SUBSAMPLE + b] = p3 + SW'(ra3[a]) - SW'(cb3[b]);
        // direction of the compare follows the sign of dy
        flip[a * SUBSAMPLE + b] = row3[a] &&
          (pos3 ? (!diff[a * SUBSAMPLE + b][SW-1] && (diff[a * SUBSAMPLE + b] != '0))
                : diff[a * SUBSAMPLE + b][SW-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      parity <= '0;
    end else if (e3_vld) begin
      parity <= parity ^ flip;
    end
  end

  // --------------------------------------------------------------------------
  // hit count, coverage by reciprocal multiply, output register
  // --------------------------------------------------------------------------
  always_comb begin
    hit_sum = '0;
    for (int i = 0; i < SS; i++) begin
      hit_sum = hit_sum + HW'(parity[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == pcmr_pkg::ST_FIN) begin
      hits <= hit_sum;
    end
  end

  assign cov_prod = MW'(hits) * COV_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.coverage    <= cov_prod[K +: pcmr_pkg::ALPHA_W];
      result.sample_hits <= pcmr_pkg::HITS_W'(hits);
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_edges_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == pcmr_pkg::ST_RUN) |-> (done_cnt <= n_reg))
    else $error("more edges processed than corners in use");

  a_edge_in_run: assert property (@(posedge clk) disable iff (rst)
    (e1_vld || e2_vld || e3_vld) |-> (state == pcmr_pkg::ST_RUN))
    else $error("edge in flight outside evaluation");

  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == pcmr_pkg::ST_OUT) |-> (32'(hits) <= SS))
    else $error("hit count above sample count");

  a_result_after_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == pcmr_pkg::ST_OUT))
    else $error("result raised outside output state");

endmodule

FILE: design/pcmr_ram.sv
// ----------------------------------------------------------------------------
// pcmr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pcmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: dv/polygon_coverage_mask_raster_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_coverage_mask_raster_test
// self-checking bench for the 4x4 supersampled even-odd coverage block:
// a directed table first, then polygon rounds with random geometry, each
// pixel transaction checked against a typed answer or an exact integer coverage predictor
// ----------------------------------------------------------------------------
module polygon_coverage_mask_raster_test;

  // block geometry as instantiated (defaults of the top level)
  localparam int MAX_CORNERS = 8;
  localparam int SUBSAMPLE   = 4;
  localparam int GAP_MAX     = 17;
  // settle a good margin past the slowest pixel evaluation
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_BUDGET  = 60;

  // one input transaction as driven on the item channel
  typedef struct packed {
    pcmr_pkg::cmd_t                      command;
    logic [pcmr_pkg::INDEX_W-1:0]        slot;
    logic signed [pcmr_pkg::COORD_W-1:0] vx;
    logic signed [pcmr_pkg::COORD_W-1:0] vy;
    logic [pcmr_pkg::PIXEL_W-1:0]        px;
    logic [pcmr_pkg::PIXEL_W-1:0]        py;
  } item_rec_t;

  // directed row: a transaction plus an optional hand-written answer
  typedef struct packed {
    pcmr_pkg::cmd_t                      command;
    logic [pcmr_pkg::INDEX_W-1:0]        slot;
    logic signed [pcmr_pkg::COORD_W-1:0] vx;
    logic signed [pcmr_pkg::COORD_W-1:0] vy;
    logic [pcmr_pkg::PIXEL_W-1:0]        px;
    logic [pcmr_pkg::PIXEL_W-1:0]        py;
    bit                                  typed;
    logic [pcmr_pkg::ALPHA_W-1:0]        cov;
    logic [pcmr_pkg::HITS_W-1:0]         hits;
  } stim_row_t;

  typedef struct {
    logic [pcmr_pkg::ALPHA_W-1:0] cov;
    logic [pcmr_pkg::HITS_W-1:0]  hits;
    logic [pcmr_pkg::PIXEL_W-1:0] px;
    logic [pcmr_pkg::PIXEL_W-1:0] py;
  } coverage_expect_t;

  // directed table, reset corner count of three throughout
  //   slots 0..2 hold the triangle (0,0) (100px,0) (0,100px); slots 3..6 hold the
  //   coordinate extremes and slot 7 the point (-1,0), unused until a wider corner count comes along
  //   later rows tilt the bottom edge off horizontal and move the third corner to (100px,100px)
  localparam int DIRECTED_COUNT = 24;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd0, 16'h0000, 16'h0000, 8'd0, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd1, 16'd1600, 16'h0000, 8'd255, 8'd255, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd2, 16'h0000, 16'd1600, 8'd0, 8'd255, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd3, 16'h8000, 16'h8000, 8'd255, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd4, 16'h7fff, 16'h7fff, 8'd0, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd5, 16'h7fff, 16'h8000, 8'd0, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd6, 16'h8000, 16'h7fff, 8'd0, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd7, 16'hffff, 16'h0000, 8'd0, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd10, 8'd10, 1'b1, 8'd255, 5'd16},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd7, 16'hffff, 16'hffff, 8'd0, 8'd0, 1'b1, 8'd255, 5'd16},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd200, 8'd200, 1'b1, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd255, 8'd255, 1'b1, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd255, 8'd0, 1'b1, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd0, 8'd255, 1'b1, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd49, 8'd50, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd50, 8'd49, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd1, 16'd1600, 16'd6, 8'd0, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd0, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd99, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_WRITE_VERTEX, 3'd2, 16'd1600, 16'd1600, 8'd0, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd99, 8'd99, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd0, 8'd0, 1'b0, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd255, 8'd0, 1'b1, 8'd0, 5'd0},
    '{pcmr_pkg::CMD_EVAL_PIXEL, 3'd0, 16'h0000, 16'h0000, 8'd0, 8'd255, 1'b1, 8'd0, 5'd0}
  };

  // corner-count settings walked by the random phases, extremes and
  // out-of-range values included (below three acts as three, above eight as eight)
  localparam logic [pcmr_pkg::VCOUNT_W-1:0] PHASE_SETTINGS [10] = '{
    4'd8, 4'd0, 4'd15, 4'd5, 4'd3, 4'd4, 4'd6, 4'd7, 4'd2, 4'd9
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcmr_item_if   item_ch ();
  pcmr_result_if result_ch ();
  pcmr_cfg_if    cfg_ch ();

  polygon_coverage_mask_raster dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  // predictor state: corner tables and the programmed corner count
  logic signed [pcmr_pkg::COORD_W-1:0] poly_x [MAX_CORNERS];
  logic signed [pcmr_pkg::COORD_W-1:0] poly_y [MAX_CORNERS];
  logic [pcmr_pkg::VCOUNT_W-1:0]       corner_count_reg =
    pcmr_pkg::VCOUNT_W'(pcmr_pkg::VCOUNT_RESET);

  coverage_expect_t pending_coverage [$];

  // when set, neither side idles (back-to-back stretches)
  bit calm = 1'b0;
  int errors = 0;
  int n_writes = 0, n_evals = 0, n_settings = 0, n_pauses = 0;
  int n_full = 0, n_partial = 0, n_empty = 0;

  // exact even-odd count over the 4x4 sample grid of one pixel; coordinates
  // are scaled by the subsample factor so every sample lands on a whole unit
  function automatic logic [pcmr_pkg::HITS_W-1:0] count_covered_samples(
      input logic [pcmr_pkg::PIXEL_W-1:0] px, input logic [pcmr_pkg::PIXEL_W-1:0] py);
    int n, hits, j;
    longint sx, sy, xi, yi, xj, yj, dy, lhs, rhs;
    bit in_poly, crossing;
    n = int'(corner_count_reg);
    if (n < pcmr_pkg::VCOUNT_MIN) n = pcmr_pkg::VCOUNT_MIN;
    if (n > MAX_CORNERS) n = MAX_CORNERS;
    hits = 0;
    for (int a = 0; a < SUBSAMPLE; a++) begin
      sy = longint'(py) * pcmr_pkg::PIXEL_SUBUNITS * SUBSAMPLE
           + (2 * a + 1) * pcmr_pkg::SAMPLE_HALF;
      for (int b = 0; b < SUBSAMPLE; b++) begin
        sx = longint'(px) * pcmr_pkg::PIXEL_SUBUNITS * SUBSAMPLE
             + (2 * b + 1) * pcmr_pkg::SAMPLE_HALF;
        in_poly = 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++) begin
          xi = longint'(poly_x[i]) * SUBSAMPLE;
          yi = longint'(poly_y[i]) * SUBSAMPLE;
          xj = longint'(poly_x[j]) * SUBSAMPLE;
          yj = longint'(poly_y[j]) * SUBSAMPLE;
          // edges that do not straddle the sample row never count,
          // horizontal edges among them
          if ((yi > sy) != (yj > sy)) begin
            dy  = yj - yi;
            lhs = (sx - xi) * dy;
            rhs = (sy - yi) * (xj - xi);
            // crossing lies right of the sample; sense flips with sign of dy
            crossing = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
            if (crossing) in_poly = !in_poly;
          end
          j = i;
        end
        if (in_poly) hits++;
      end
    end
    return hits[pcmr_pkg::HITS_W-1:0];
  endfunction

  function automatic item_rec_t make_write(input int slot, input int x, input int y);
    item_rec_t rec;
    rec.command = pcmr_pkg::CMD_WRITE_VERTEX;
    rec.slot    = slot[pcmr_pkg::INDEX_W-1:0];
    rec.vx      = x[pcmr_pkg::COORD_W-1:0];
    rec.vy      = y[pcmr_pkg::COORD_W-1:0];
    // pixel fields are don't-care on a corner write
    rec.px      = pcmr_pkg::PIXEL_W'($urandom_range(0, 255));
    rec.py      = pcmr_pkg::PIXEL_W'($urandom_range(0, 255));
    return rec;
  endfunction

  function automatic item_rec_t make_eval(input int px, input int py);
    item_rec_t rec;
    rec.command = pcmr_pkg::CMD_EVAL_PIXEL;
    rec.slot    = pcmr_pkg::INDEX_W'($urandom_range(0, 7));
    rec.vx      = pcmr_pkg::COORD_W'($urandom_range(0, 65535));
    rec.vy      = pcmr_pkg::COORD_W'($urandom_range(0, 65535));
    rec.px      = px[pcmr_pkg::PIXEL_W-1:0];
    rec.py      = py[pcmr_pkg::PIXEL_W-1:0];
    return rec;
  endfunction

  function automatic int to_pixel(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // corner coordinate around a center, sometimes snapped onto a sample
  // column or row so the exact-equality cases of the crossing test get hit
  function automatic int pick_coord(input int center, input int span);
    int v;
    v = center + int'($urandom_range(0, 2 * span)) - span;
    if ($urandom_range(0, 2) == 0)
      v = (v & ~(pcmr_pkg::PIXEL_SUBUNITS - 1)) | (2 + 4 * int'($urandom_range(0, 3)));
    return v;
  endfunction

  // one item transaction: idle gap, drive at the falling edge, wait for the
  // handshake, then update the predictor at the accepting edge
  task automatic send_item(input item_rec_t rec, input bit typed,
                           input logic [pcmr_pkg::ALPHA_W-1:0] typed_cov,
                           input logic [pcmr_pkg::HITS_W-1:0] typed_hits);
    int gap;
    coverage_expect_t want;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_ch.command      <= rec.command;
    item_ch.vertex_index <= rec.slot;
    item_ch.vertex_x     <= rec.vx;
    item_ch.vertex_y     <= rec.vy;
    item_ch.pixel_x      <= rec.px;
    item_ch.pixel_y      <= rec.py;
    item_ch.valid        <= 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    if (rec.command == pcmr_pkg::CMD_WRITE_VERTEX) begin
      poly_x[rec.slot] = rec.vx;
      poly_y[rec.slot] = rec.vy;
      n_writes++;
    end else begin
      want.hits = typed ? typed_hits : count_covered_samples(rec.px, rec.py);
      want.cov  = typed ? typed_cov
                        : pcmr_pkg::ALPHA_W'((int'(want.hits) * pcmr_pkg::FULL_ALPHA)
                                             / (SUBSAMPLE * SUBSAMPLE));
      want.px   = rec.px;
      want.py   = rec.py;
      pending_coverage.push_back(want);
      n_evals++;
    end
  endtask

  task automatic park_item_channel();
    @(negedge clk);
    item_ch.valid <= 1'b0;
  endtask

  // sender holds off until every pixel in flight has been answered
  task automatic settle_block();
    park_item_channel();
    while (pending_coverage.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    n_pauses++;
  endtask

  // corner count is only written with the block idle (cfg is always ready)
  task automatic write_vertex_count(input logic [pcmr_pkg::VCOUNT_W-1:0] setting);
    @(negedge clk);
    cfg_ch.vertex_count <= setting;
    cfg_ch.valid        <= 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    corner_count_reg = setting;
    n_settings++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one phase: program a corner count, then rounds of fresh polygons with
  // pixels around them; about one round in ten is noise instead
  task automatic run_phase(input logic [pcmr_pkg::VCOUNT_W-1:0] setting, input int budget,
                           input bit probe_first);
    int used, n_eff, cx, cy, span, vx, vy, last_y;
    settle_block();
    write_vertex_count(setting);
    n_eff = int'(setting);
    if (n_eff < pcmr_pkg::VCOUNT_MIN) n_eff = pcmr_pkg::VCOUNT_MIN;
    if (n_eff > MAX_CORNERS) n_eff = MAX_CORNERS;
    used = 0;
    // evaluate the table as the directed part left it, extremes included
    if (probe_first) begin
      repeat (4) begin
        send_item(make_eval($urandom_range(0, 255), $urandom_range(0, 255)), 1'b0, '0, '0);
        used++;
      end
    end
    while (used < budget) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // stray full-range corners into any slot, then scattered pixels
        repeat ($urandom_range(1, 3)) begin
          send_item(make_write($urandom_range(0, 7), $urandom_range(0, 65535),
                               $urandom_range(0, 65535)), 1'b0, '0, '0);
          used++;
        end
        repeat ($urandom_range(1, 3)) begin
          send_item(make_eval($urandom_range(0, 255), $urandom_range(0, 255)),
                    1'b0, '0, '0);
          used++;
        end
      end else begin
        cx   = $urandom_range(4, 251);
        cy   = $urandom_range(4, 251);
        // mostly pixel-sized shapes so partial coverage is common
        span = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
        last_y = 0;
        for (int k = 0; k < n_eff; k++) begin
          vx = pick_coord(cx * pcmr_pkg::PIXEL_SUBUNITS, span * pcmr_pkg::PIXEL_SUBUNITS);
          // repeat the previous y now and then for horizontal edges
          if (k > 0 && $urandom_range(0, 3) == 0) vy = last_y;
          else vy = pick_coord(cy * pcmr_pkg::PIXEL_SUBUNITS, span * pcmr_pkg::PIXEL_SUBUNITS);
          last_y = vy;
          send_item(make_write(k, vx, vy), 1'b0, '0, '0);
          used++;
        end
        repeat ($urandom_range(3, 10)) begin
          send_item(make_eval(to_pixel(cx + int'($urandom_range(0, 2 * span + 2)) - span - 1),
                              to_pixel(cy + int'($urandom_range(0, 2 * span + 2)) - span - 1)),
                    1'b0, '0, '0);
          used++;
        end
      end
      // occasional mid-phase hold-off until the pipe is empty
      if ($urandom_range(0, 24) == 0) settle_block();
    end
  endtask

  // result side: random stall per transaction, compare against oldest entry
  initial begin : result_check
    int stall;
    coverage_expect_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
      if (pending_coverage.size() == 0) begin
        $display("%0t: result transaction with nothing expected: coverage %0d hits %0d",
                 $time, result_ch.coverage, result_ch.sample_hits);
        errors++;
      end else begin
        want = pending_coverage.pop_front();
        if (result_ch.sample_hits !== want.hits) begin
          $display("%0t: pixel (%0d,%0d) sample_hits expected %0d, actual %0d",
                   $time, want.px, want.py, want.hits, result_ch.sample_hits);
          errors++;
        end
        if (result_ch.coverage !== want.cov) begin
          $display("%0t: pixel (%0d,%0d) coverage expected %0d, actual %0d",
                   $time, want.px, want.py, want.cov, result_ch.coverage);
          errors++;
        end
        if (want.hits == 0) n_empty++;
        else if (want.hits == SUBSAMPLE * SUBSAMPLE) n_full++;
        else n_partial++;
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    stim_row_t row;
    item_rec_t rec;
    item_ch.valid        = 1'b0;
    item_ch.command      = pcmr_pkg::CMD_WRITE_VERTEX;
    item_ch.vertex_index = '0;
    item_ch.vertex_x     = '0;
    item_ch.vertex_y     = '0;
    item_ch.pixel_x      = '0;
    item_ch.pixel_y      = '0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.vertex_count  = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table at the reset corner count
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      row = DIRECTED_ROWS[r];
      rec = '{row.command, row.slot, row.vx, row.vy, row.px, row.py};
      calm = (r >= 16);
      send_item(rec, row.typed, row.cov, row.hits);
    end

    // random phases over the listed corner-count settings, plus two drawn at random
    for (int p = 0; p < 12; p++) begin
      if (p < 10) run_phase(PHASE_SETTINGS[p], PHASE_BUDGET, p == 0);
      else run_phase(pcmr_pkg::VCOUNT_W'($urandom_range(0, 15)), PHASE_BUDGET, 1'b0);
    end

    park_item_channel();
    while (pending_coverage.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d corner writes, %0d pixel evaluations, %0d corner-count settings, %0d drains",
             n_writes, n_evals, n_settings, n_pauses);
    $display("coverage seen: %0d full, %0d partial, %0d empty pixels",
             n_full, n_partial, n_empty);
    if (errors == 0 && pending_coverage.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
